// File: sv/fem9_pkg.sv
// Shared constants, types and helpers for the nine-point stencil off-diagonal block.
`default_nettype none

package fem9_pkg;

	localparam int MAX_COLS = 1024;
	localparam int MAX_ROWS = 1024;
	localparam int SAMPLE_W = 32;
	localparam int WGT_W    = 18;
	localparam int SIZE_W   = 11;
	localparam int IDX_W    = 3;
	localparam int COL_W    = $clog2(MAX_COLS);
	localparam int ROW_W    = $clog2(MAX_ROWS);
	localparam int CLR_W    = COL_W + 1;
	localparam int NPTS     = 4;
	localparam int CSUM_W   = SAMPLE_W + 2;
	localparam int PSUM_W   = SAMPLE_W + 1;
	localparam int FRAC_SH  = WGT_W - 1;

	// points a sample can complete, in emission order
	localparam int PT_UL = 0;
	localparam int PT_UR = 1;
	localparam int PT_LL = 2;
	localparam int PT_LR = 3;

	localparam logic [SIZE_W-1:0] SIZE_RST   = SIZE_W'(2);
	localparam logic [WGT_W-1:0]  CORNER_RST = WGT_W'(-16384);

	typedef enum logic [IDX_W-1:0] {
		REG_COLS       = 3'd0,
		REG_ROWS       = 3'd1,
		REG_CORNER     = 3'd2,
		REG_VERT       = 3'd3,
		REG_HORIZ      = 3'd4,
		REG_VERT_HALF  = 3'd5,
		REG_HORIZ_HALF = 3'd6
	} cfg_reg_t;

	typedef logic [SAMPLE_W-1:0] smp_t;

	typedef struct packed {
		logic [SIZE_W-1:0] nc;
		logic [SIZE_W-1:0] nr;
		logic [WGT_W-1:0]  fc;
		logic [WGT_W-1:0]  fey;
		logic [WGT_W-1:0]  fex;
		logic [WGT_W-1:0]  hey;
		logic [WGT_W-1:0]  hex;
	} cfg_t;

	typedef struct packed {
		smp_t [2:0][2:0]    g;
		logic [COL_W-1:0]   x;
		logic [ROW_W-1:0]   y;
		logic [NPTS-1:0]    pts;
	} item_t;

	typedef struct packed {
		logic [CSUM_W-1:0] csum;
		logic [PSUM_W-1:0] vsum;
		logic [PSUM_W-1:0] hsum;
		logic [WGT_W-1:0]  cw;
		logic [WGT_W-1:0]  vw;
		logic [WGT_W-1:0]  hw;
		logic [COL_W-1:0]  pc;
		logic [ROW_W-1:0]  pr;
		logic              last;
	} pnt_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
			input logic [SIZE_W-1:0] maxv);
		logic [SIZE_W-1:0] r;
		if (v < SIZE_W'(2)) r = SIZE_W'(2);
		else if (v > maxv) r = maxv;
		else r = v;
		return r;
	endfunction

endpackage

`default_nettype wire

// File: sv/fem_nine_point_stencil_offdiag.sv
// Top level: configuration registers and the stencil pipeline.
`default_nettype none

// Takes one Q16.16 sample per cycle in raster order and returns the off-diagonal
// bilinear FEM Laplacian sum of each grid point once its last neighbor has arrived:
// a sample completes zero to four points, one result beat per cycle leaves the
// block while out_ready is high, so samples on the last column or last row hold
// the input while their results drain. The line memory (1024 words of two
// samples) takes one read and one write per cycle, which sets the one-sample-per-
// cycle rate; the results of a sample pass the window, sequencer and multiply
// registers and leave one per cycle. After reset the line memory is cleared word
// by word, and in_ready stays low until it is done. Write configuration only
// while no sample is in flight.
module fem_nine_point_stencil_offdiag
	import fem9_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [IDX_W-1:0]    cfg_index,
	input  logic [WGT_W-1:0]    cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                frame_start,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] product,
	output logic [COL_W-1:0]    point_col,
	output logic [ROW_W-1:0]    point_row,
	output logic                clipped,
	output logic                last
);

	logic [SIZE_W-1:0] cols_q, rows_q;
	logic [WGT_W-1:0]  corner_q, vert_q, horiz_q, vert_half_q, horiz_half_q;
	cfg_t              cfg;

	logic  f_valid, f_ready;
	item_t f_item;
	logic  p_valid, p_ready;
	pnt_t  p_pnt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_q       <= SIZE_RST;
			rows_q       <= SIZE_RST;
			corner_q     <= CORNER_RST;
			vert_q       <= '0;
			horiz_q      <= '0;
			vert_half_q  <= '0;
			horiz_half_q <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_COLS:       cols_q       <= cfg_data[SIZE_W-1:0];
				REG_ROWS:       rows_q       <= cfg_data[SIZE_W-1:0];
				REG_CORNER:     corner_q     <= cfg_data;
				REG_VERT:       vert_q       <= cfg_data;
				REG_HORIZ:      horiz_q      <= cfg_data;
				REG_VERT_HALF:  vert_half_q  <= cfg_data;
				REG_HORIZ_HALF: horiz_half_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		cfg.nc  = clamp_size(cols_q, SIZE_W'(MAX_COLS));
		cfg.nr  = clamp_size(rows_q, SIZE_W'(MAX_ROWS));
		cfg.fc  = corner_q;
		cfg.fey = vert_q;
		cfg.fex = horiz_q;
		cfg.hey = vert_half_q;
		cfg.hex = horiz_half_q;
	end

	fem9_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.sample      (sample),
		.frame_start (frame_start),
		.dn_valid    (f_valid),
		.dn_ready    (f_ready),
		.dn_item     (f_item)
	);

	fem9_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.up_valid (f_valid),
		.up_ready (f_ready),
		.up_item  (f_item),
		.pt_valid (p_valid),
		.pt_ready (p_ready),
		.pt       (p_pnt)
	);

	fem9_mac u_mac (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (p_valid),
		.pt_ready  (p_ready),
		.pt        (p_pnt),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.product   (product),
		.point_col (point_col),
		.point_row (point_row),
		.clipped   (clipped),
		.last      (last)
	);

endmodule

`default_nettype wire

// File: sv/fem9_front.sv
// Raster position counters, two-row line memory with clear pass, and sample window.
`default_nettype none

module fem9_front
	import fem9_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cfg_t                cfg,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic                frame_start,
	output logic                dn_valid,
	input  logic                dn_ready,
	output item_t               dn_item
);

	logic [2*SAMPLE_W-1:0] line_mem [MAX_COLS];

	logic [CLR_W-1:0]      clr_q;
	logic [COL_W-1:0]      col_q;
	logic [ROW_W-1:0]      row_q;
	logic                  busy, accept, s1_adv, has_pts;
	logic [SIZE_W-1:0]     c_st, r_st, c_nx, r_nx;
	logic [COL_W-1:0]      x0;
	logic [ROW_W-1:0]      y0;
	logic                  x_end, y_end;
	logic [NPTS-1:0]       pts0;

	logic                  valid_s1;
	logic [SAMPLE_W-1:0]   sample_s1;
	logic [COL_W-1:0]      x_s1;
	logic [ROW_W-1:0]      y_s1;
	logic [NPTS-1:0]       pts_s1;
	logic                  fwd_s1;
	logic [2*SAMPLE_W-1:0] fwdw_s1;
	logic [2*SAMPLE_W-1:0] rd_q;

	logic [2*SAMPLE_W-1:0] line, wr_word, mem_wd;
	logic [SAMPLE_W-1:0]   cur, prv;
	logic                  mem_we;
	logic [COL_W-1:0]      mem_wa;

	smp_t w1_q, w2_q, w4_q, w5_q, sp1_q, sp2_q;

	assign busy     = (clr_q != CLR_W'(MAX_COLS));
	assign has_pts  = (pts_s1 != '0);
	assign dn_valid = valid_s1 && has_pts;
	assign s1_adv   = valid_s1 && (!has_pts || dn_ready);
	assign in_ready = !busy && (!valid_s1 || s1_adv);
	assign accept   = in_valid && in_ready;

	// position of the incoming sample and of the one after it
	always_comb begin
		c_st = frame_start ? '0 : SIZE_W'(col_q);
		r_st = frame_start ? '0 : SIZE_W'(row_q);
		if (c_st >= cfg.nc) begin
			c_st = '0;
			r_st = r_st + 1'b1;
		end
		if (r_st >= cfg.nr) r_st = '0;
		x0 = c_st[COL_W-1:0];
		y0 = r_st[ROW_W-1:0];
		x_end = (SIZE_W'(x0) == cfg.nc - 1'b1);
		y_end = (SIZE_W'(y0) == cfg.nr - 1'b1);

		c_nx = SIZE_W'(x0) + 1'b1;
		r_nx = SIZE_W'(y0);
		if (c_nx >= cfg.nc) begin
			c_nx = '0;
			r_nx = SIZE_W'(y0) + 1'b1;
			if (r_nx >= cfg.nr) r_nx = '0;
		end

		pts0 = '0;
		pts0[PT_UL] = (x0 != '0) && (y0 != '0);
		pts0[PT_UR] = pts0[PT_UL] && x_end;
		pts0[PT_LL] = y_end && (x0 != '0);
		pts0[PT_LR] = pts0[PT_LL] && x_end;
	end

	// line word: low half holds even rows, high half odd rows
	always_comb begin
		line = fwd_s1 ? fwdw_s1 : rd_q;
		if (y_s1[0]) begin
			cur = line[2*SAMPLE_W-1:SAMPLE_W];
			prv = line[SAMPLE_W-1:0];
			wr_word = {sample_s1, line[SAMPLE_W-1:0]};
		end else begin
			cur = line[SAMPLE_W-1:0];
			prv = line[2*SAMPLE_W-1:SAMPLE_W];
			wr_word = {line[2*SAMPLE_W-1:SAMPLE_W], sample_s1};
		end
		mem_we = busy || s1_adv;
		mem_wa = busy ? clr_q[COL_W-1:0] : x_s1;
		mem_wd = busy ? '0 : wr_word;
	end

	always_ff @(posedge clk) begin
		if (mem_we) line_mem[mem_wa] <= mem_wd;
		if (accept) rd_q <= line_mem[x0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q    <= '0;
			col_q    <= '0;
			row_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (busy) clr_q <= clr_q + 1'b1;
			if (accept) begin
				col_q <= c_nx[COL_W-1:0];
				row_q <= r_nx[ROW_W-1:0];
			end
			if (accept) valid_s1 <= 1'b1;
			else if (s1_adv) valid_s1 <= 1'b0;
		end
	end

	// same-entry write and read at one edge: take the word being written
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			x_s1      <= x0;
			y_s1      <= y0;
			pts_s1    <= pts0;
			fwd_s1    <= s1_adv && (x_s1 == x0);
			fwdw_s1   <= wr_word;
		end
		if (s1_adv) begin
			w1_q  <= w2_q;
			w2_q  <= cur;
			w4_q  <= w5_q;
			w5_q  <= prv;
			sp2_q <= sp1_q;
			sp1_q <= sample_s1;
		end
	end

	always_comb begin
		dn_item.g[0][0] = w1_q;
		dn_item.g[0][1] = w2_q;
		dn_item.g[0][2] = cur;
		dn_item.g[1][0] = w4_q;
		dn_item.g[1][1] = w5_q;
		dn_item.g[1][2] = prv;
		dn_item.g[2][0] = sp2_q;
		dn_item.g[2][1] = sp1_q;
		dn_item.g[2][2] = sample_s1;
		dn_item.x       = x_s1;
		dn_item.y       = y_s1;
		dn_item.pts     = pts_s1;
	end

	a_clear_idle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !valid_s1)
		else $error("sample in flight during line clear");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_adv |=> valid_s1 && $stable(x_s1) && $stable(y_s1))
		else $error("stalled window stage lost its position");

endmodule

`default_nettype wire

// File: sv/fem9_seq.sv
// Point sequencer: walks the points a sample completes and forms the weighted-sum operands.
`default_nettype none

module fem9_seq
	import fem9_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  cfg_t  cfg,
	input  logic  up_valid,
	output logic  up_ready,
	input  item_t up_item,
	output logic  pt_valid,
	input  logic  pt_ready,
	output pnt_t  pt
);

	logic            valid_s2;
	item_t           item_s2;
	logic [NPTS-1:0] mask_s2;
	logic            valid_s3;
	pnt_t            pnt_s3;

	logic [NPTS-1:0]     sel_oh, rest;
	logic                fire, cr_off, cc_off;
	logic                left, right, up, dn;
	logic [COL_W-1:0]    pc;
	logic [ROW_W-1:0]    pr;
	smp_t                g4   [4][4];
	smp_t                rsel [3][4];
	smp_t                nb   [3][3];
	logic signed [SAMPLE_W-1:0] t00, t02, t20, t22, t01, t21, t10, t12;
	pnt_t                pnt_d;

	assign sel_oh   = mask_s2 & (~mask_s2 + 1'b1);
	assign rest     = mask_s2 & ~sel_oh;
	assign cr_off   = sel_oh[PT_LL] | sel_oh[PT_LR];
	assign cc_off   = sel_oh[PT_UR] | sel_oh[PT_LR];
	assign fire     = valid_s2 && (!valid_s3 || pt_ready);
	assign up_ready = !valid_s2 || (fire && (rest == '0));
	assign pt_valid = valid_s3;
	assign pt       = pnt_s3;

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				g4[r][c] = '0;
			end
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				g4[r][c] = item_s2.g[r][c];
			end
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 4; c++) begin
				rsel[r][c] = cr_off ? g4[r+1][c] : g4[r][c];
			end
		end
		for (int r = 0; r < 3; r++) begin
			for (int c = 0; c < 3; c++) begin
				nb[r][c] = cc_off ? rsel[r][c+1] : rsel[r][c];
			end
		end
	end

	always_comb begin
		pc    = cc_off ? item_s2.x : item_s2.x - 1'b1;
		pr    = cr_off ? item_s2.y : item_s2.y - 1'b1;
		left  = (pc == '0);
		right = (SIZE_W'(pc) == cfg.nc - 1'b1);
		up    = (pr != '0);
		dn    = (SIZE_W'(pr) != cfg.nr - 1'b1);

		t00 = (up && !left)  ? nb[0][0] : '0;
		t02 = (up && !right) ? nb[0][2] : '0;
		t20 = (dn && !left)  ? nb[2][0] : '0;
		t22 = (dn && !right) ? nb[2][2] : '0;
		t01 = up     ? nb[0][1] : '0;
		t21 = dn     ? nb[2][1] : '0;
		t10 = !left  ? nb[1][0] : '0;
		t12 = !right ? nb[1][2] : '0;

		pnt_d.csum = CSUM_W'(t00) + CSUM_W'(t02) + CSUM_W'(t20) + CSUM_W'(t22);
		pnt_d.vsum = PSUM_W'(t01) + PSUM_W'(t21);
		pnt_d.hsum = PSUM_W'(t10) + PSUM_W'(t12);
		pnt_d.cw   = cfg.fc;
		pnt_d.vw   = (left || right) ? cfg.hey : cfg.fey;
		pnt_d.hw   = (!up || !dn) ? cfg.hex : cfg.fex;
		pnt_d.pc   = pc;
		pnt_d.pr   = pr;
		pnt_d.last = (rest == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (up_valid && up_ready) valid_s2 <= 1'b1;
			else if (fire && (rest == '0)) valid_s2 <= 1'b0;
			if (fire) valid_s3 <= 1'b1;
			else if (pt_ready) valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && up_ready) begin
			item_s2 <= up_item;
			mask_s2 <= up_item.pts;
		end else if (fire) begin
			mask_s2 <= rest;
		end
		if (fire) pnt_s3 <= pnt_d;
	end

	a_mask_live: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> mask_s2 != '0)
		else $error("sequencer holds a sample with no points left");

	a_one_point: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> $onehot(sel_oh))
		else $error("point select not one-hot");

endmodule

`default_nettype wire

// File: sv/fem9_mac.sv
// Weighted sum of neighbor groups, rounding, saturation and output register.
`default_nettype none

module fem9_mac
	import fem9_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pt_valid,
	output logic                pt_ready,
	input  pnt_t                pt,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SAMPLE_W-1:0] product,
	output logic [COL_W-1:0]    point_col,
	output logic [ROW_W-1:0]    point_row,
	output logic                clipped,
	output logic                last
);

	localparam int PC_W  = CSUM_W + WGT_W;
	localparam int PV_W  = PSUM_W + WGT_W;
	localparam int ACC_W = PC_W + 2;
	localparam int SH_W  = ACC_W - FRAC_SH;
	localparam logic signed [ACC_W-1:0] RND = ACC_W'(1) <<< (FRAC_SH - 1);
	localparam logic [SAMPLE_W-1:0] SAT_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
	localparam logic [SAMPLE_W-1:0] SAT_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

	logic signed [CSUM_W-1:0] csum;
	logic signed [PSUM_W-1:0] vsum, hsum;
	logic signed [WGT_W-1:0]  cw, vw, hw;

	logic                   v4, v5, v6, rdy5, rdy6;
	logic signed [PC_W-1:0] prc_s4;
	logic signed [PV_W-1:0] prv_s4, prh_s4;
	logic [COL_W-1:0]       pc_s4, pc_s5, pc_s6;
	logic [ROW_W-1:0]       pr_s4, pr_s5, pr_s6;
	logic                   last_s4, last_s5, last_s6;
	logic signed [ACC_W-1:0] acc_s5;
	logic [SAMPLE_W-1:0]    product_s6;
	logic                   clip_s6;

	logic [SH_W-1:0]             sh;
	logic [SH_W-SAMPLE_W:0]      top;
	logic                        ovf;
	logic [SAMPLE_W-1:0]         prod_d;

	assign csum = $signed(pt.csum);
	assign vsum = $signed(pt.vsum);
	assign hsum = $signed(pt.hsum);
	assign cw   = $signed(pt.cw);
	assign vw   = $signed(pt.vw);
	assign hw   = $signed(pt.hw);

	assign rdy6     = !v6 || out_ready;
	assign rdy5     = !v5 || rdy6;
	assign pt_ready = !v4 || rdy5;

	// floor shift, then clamp to the sample range
	always_comb begin
		sh     = acc_s5[ACC_W-1:FRAC_SH];
		top    = sh[SH_W-1:SAMPLE_W-1];
		ovf    = !((&top) || !(|top));
		prod_d = ovf ? (sh[SH_W-1] ? SAT_MIN : SAT_MAX) : sh[SAMPLE_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v4 <= 1'b0;
			v5 <= 1'b0;
			v6 <= 1'b0;
		end else begin
			if (pt_ready) v4 <= pt_valid;
			if (rdy5) v5 <= v4;
			if (rdy6) v6 <= v5;
		end
	end

	always_ff @(posedge clk) begin
		if (pt_ready && pt_valid) begin
			prc_s4  <= PC_W'(csum) * PC_W'(cw);
			prv_s4  <= PV_W'(vsum) * PV_W'(vw);
			prh_s4  <= PV_W'(hsum) * PV_W'(hw);
			pc_s4   <= pt.pc;
			pr_s4   <= pt.pr;
			last_s4 <= pt.last;
		end
		if (rdy5 && v4) begin
			acc_s5  <= ACC_W'(prc_s4) + ACC_W'(prv_s4) + ACC_W'(prh_s4) + RND;
			pc_s5   <= pc_s4;
			pr_s5   <= pr_s4;
			last_s5 <= last_s4;
		end
		if (rdy6 && v5) begin
			product_s6 <= prod_d;
			clip_s6    <= ovf;
			pc_s6      <= pc_s5;
			pr_s6      <= pr_s5;
			last_s6    <= last_s5;
		end
	end

	assign out_valid = v6;
	assign product   = product_s6;
	assign point_col = pc_s6;
	assign point_row = pr_s6;
	assign clipped   = clip_s6;
	assign last      = last_s6;

	a_acc_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v5 && !rdy6 |=> v5 && $stable(acc_s5))
		else $error("stalled accumulator changed");

endmodule

`default_nettype wire

// File: bench/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for the nine-point stencil block: directed grids, random streams.
module tb_top;
	import fem9_pkg::*;

	localparam int SETTLE     = 12;
	localparam int RAND_ITEMS = 205;
	localparam int QUIET_FROM = 165;
	localparam longint SMP_MAX = (64'sd1 <<< (SAMPLE_W - 1)) - 1;
	localparam longint SMP_MIN = -(64'sd1 <<< (SAMPLE_W - 1));

	typedef struct {
		logic [SAMPLE_W-1:0] product;
		logic [COL_W-1:0]    col;
		logic [ROW_W-1:0]    row;
		logic                clipped;
		logic                last;
	} point_res_t;

	typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

	typedef struct {
		row_kind_t           kind;
		cfg_reg_t            idx;
		logic [WGT_W-1:0]    data;
		logic [SAMPLE_W-1:0] smp;
		logic                fs;
		logic                typed;
		logic [SAMPLE_W-1:0] t_prod;
		logic                t_clip;
	} plan_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [IDX_W-1:0]    cfg_index = '0;
	logic [WGT_W-1:0]    cfg_data = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [SAMPLE_W-1:0] sample = '0;
	logic                frame_start = 1'b0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [SAMPLE_W-1:0] product;
	logic [COL_W-1:0]    point_col;
	logic [ROW_W-1:0]    point_row;
	logic                clipped;
	logic                last;

	fem_nine_point_stencil_offdiag dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.frame_start(frame_start),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.product    (product),
		.point_col  (point_col),
		.point_row  (point_row),
		.clipped    (clipped),
		.last       (last)
	);

	always #10 clk = ~clk;

	// stencil shadow state
	logic [SAMPLE_W-1:0] ls_mem [0:2*MAX_COLS-1] = '{default: '0};
	logic [SAMPLE_W-1:0] win [0:5] = '{default: '0};
	longint              nbr [0:3][0:3];
	int unsigned         col_pos = 0;
	int unsigned         row_pos = 0;
	logic [SIZE_W-1:0]   r_cols = SIZE_RST;
	logic [SIZE_W-1:0]   r_rows = SIZE_RST;
	logic [WGT_W-1:0]    w_corner = CORNER_RST;
	logic [WGT_W-1:0]    w_vert = '0;
	logic [WGT_W-1:0]    w_horiz = '0;
	logic [WGT_W-1:0]    w_vhalf = '0;
	logic [WGT_W-1:0]    w_hhalf = '0;

	point_res_t expected_points [$];
	plan_row_t  plan [$];

	bit sender_idle = 1'b1;
	bit ready_idle = 1'b1;
	int stall_left = 0;
	int fails = 0;
	int beats_checked = 0;
	int samples_sent = 0;
	int cfg_writes = 0;
	int phases = 0;
	int rand_sent = 0;

	function automatic int unsigned clip_dim(input logic [SIZE_W-1:0] v, input int unsigned maxv);
		if (v < 2) return 2;
		if (v > maxv) return maxv;
		return 32'(v);
	endfunction

	function automatic longint sx(input logic [SAMPLE_W-1:0] v);
		return longint'($signed(v));
	endfunction

	function automatic point_res_t eval_point(input int cr, input int cc, input int unsigned pc,
			input int unsigned pr, input int unsigned nc, input int unsigned nr);
		point_res_t res;
		longint fc, fey, fex, hey, hex, hw, vw, acc, r;
		logic up, dn, lft, rgt, clip;
		fc  = longint'($signed(w_corner));
		fey = longint'($signed(w_vert));
		fex = longint'($signed(w_horiz));
		hey = longint'($signed(w_vhalf));
		hex = longint'($signed(w_hhalf));
		up = 1'b0;
		dn = 1'b0;
		acc = 0;
		clip = 1'b0;
		lft = (pc == 0);
		rgt = (pc == nc - 1);
		if (pr == 0) begin
			dn = 1'b1;
			hw = hex;
		end else if (pr == nr - 1) begin
			up = 1'b1;
			hw = hex;
		end else begin
			up = 1'b1;
			dn = 1'b1;
			hw = fex;
		end
		vw = (lft || rgt) ? hey : fey;
		if (up) begin
			if (!lft) acc += fc * nbr[cr-1][cc-1];
			if (!rgt) acc += fc * nbr[cr-1][cc+1];
			acc += vw * nbr[cr-1][cc];
		end
		if (dn) begin
			if (!lft) acc += fc * nbr[cr+1][cc-1];
			if (!rgt) acc += fc * nbr[cr+1][cc+1];
			acc += vw * nbr[cr+1][cc];
		end
		if (!lft) acc += hw * nbr[cr][cc-1];
		if (!rgt) acc += hw * nbr[cr][cc+1];
		r = (acc + (64'sd1 <<< (FRAC_SH - 1))) >>> FRAC_SH;
		if (r > SMP_MAX) begin
			r = SMP_MAX;
			clip = 1'b1;
		end
		if (r < SMP_MIN) begin
			r = SMP_MIN;
			clip = 1'b1;
		end
		res.product = r[SAMPLE_W-1:0];
		res.col = pc[COL_W-1:0];
		res.row = pr[ROW_W-1:0];
		res.clipped = clip;
		res.last = 1'b0;
		return res;
	endfunction

	// advance the shadow by one accepted sample and queue the points it completes
	function automatic void stencil_step(input logic [SAMPLE_W-1:0] s, input logic fs);
		point_res_t pts [0:3];
		int unsigned nc, nr, x, y, cb, pb;
		int n;
		nc = clip_dim(r_cols, MAX_COLS);
		nr = clip_dim(r_rows, MAX_ROWS);
		if (fs) begin
			col_pos = 0;
			row_pos = 0;
		end
		if (col_pos >= nc) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= nr) row_pos = 0;
		x = col_pos;
		y = row_pos;
		cb = (y & 1) * MAX_COLS;
		pb = ((y + 1) & 1) * MAX_COLS;
		win[0] = win[1];
		win[1] = win[2];
		win[2] = ls_mem[cb + x];
		win[3] = win[4];
		win[4] = win[5];
		win[5] = ls_mem[pb + x];
		ls_mem[cb + x] = s;
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				nbr[i][j] = 0;
		for (int j = 0; j < 3; j++) begin
			nbr[0][j] = sx(win[j]);
			nbr[1][j] = sx(win[3 + j]);
		end
		nbr[2][0] = (x >= 2) ? sx(ls_mem[cb + x - 2]) : 0;
		nbr[2][1] = (x >= 1) ? sx(ls_mem[cb + x - 1]) : 0;
		nbr[2][2] = sx(s);
		if (x < 2) begin
			nbr[0][0] = 0;
			nbr[1][0] = 0;
		end
		if (x < 1) begin
			nbr[0][1] = 0;
			nbr[1][1] = 0;
		end
		n = 0;
		if (x >= 1 && y >= 1) begin
			pts[n] = eval_point(1, 1, x - 1, y - 1, nc, nr);
			n++;
			if (x == nc - 1) begin
				pts[n] = eval_point(1, 2, x, y - 1, nc, nr);
				n++;
			end
		end
		if (y == nr - 1 && x >= 1) begin
			pts[n] = eval_point(2, 1, x - 1, y, nc, nr);
			n++;
			if (x == nc - 1) begin
				pts[n] = eval_point(2, 2, x, y, nc, nr);
				n++;
			end
		end
		for (int i = 0; i < n; i++) begin
			pts[i].last = (i == n - 1);
			expected_points.push_back(pts[i]);
		end
		col_pos = x + 1;
		if (col_pos >= nc) begin
			col_pos = 0;
			row_pos = y + 1;
			if (row_pos >= nr) row_pos = 0;
		end
	endfunction

	function automatic void add_cfg(input cfg_reg_t idx, input logic [WGT_W-1:0] d);
		plan_row_t r;
		r.kind = ROW_CFG;
		r.idx = idx;
		r.data = d;
		r.smp = '0;
		r.fs = 1'b0;
		r.typed = 1'b0;
		r.t_prod = '0;
		r.t_clip = 1'b0;
		plan.push_back(r);
	endfunction

	function automatic void add_smp(input logic [SAMPLE_W-1:0] s, input logic fs,
			input logic typed = 1'b0, input logic [SAMPLE_W-1:0] tp = '0, input logic tc = 1'b0);
		plan_row_t r;
		r.kind = ROW_SMP;
		r.idx = REG_COLS;
		r.data = '0;
		r.smp = s;
		r.fs = fs;
		r.typed = typed;
		r.t_prod = tp;
		r.t_clip = tc;
		plan.push_back(r);
	endfunction

	function automatic logic [SAMPLE_W-1:0] pick_sample();
		logic [19:0] lo;
		lo = 20'($urandom);
		case ($urandom_range(0, 7))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return {{12{lo[19]}}, lo};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [SIZE_W-1:0] pick_dim();
		case ($urandom_range(0, 15))
			0: return SIZE_W'($urandom_range(0, 1));
			1: return SIZE_W'(MAX_COLS);
			2: return '1;
			3: return SIZE_W'($urandom_range(1025, 2046));
			default: return SIZE_W'($urandom_range(2, 6));
		endcase
	endfunction

	function automatic logic [WGT_W-1:0] pick_weight();
		case ($urandom_range(0, 7))
			0: return 18'h20000;
			1: return 18'h1FFFF;
			2: return '0;
			3: return 18'h3C000;
			default: return WGT_W'($urandom);
		endcase
	endfunction

	task automatic write_reg(input cfg_reg_t idx, input logic [WGT_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		case (idx)
			REG_COLS:       r_cols = d[SIZE_W-1:0];
			REG_ROWS:       r_rows = d[SIZE_W-1:0];
			REG_CORNER:     w_corner = d;
			REG_VERT:       w_vert = d;
			REG_HORIZ:      w_horiz = d;
			REG_VERT_HALF:  w_vhalf = d;
			REG_HORIZ_HALF: w_hhalf = d;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic fs);
		in_valid <= 1'b1;
		sample <= s;
		frame_start <= fs;
		do @(posedge clk); while (!in_ready);
		stencil_step(s, fs);
		samples_sent++;
	endtask

	task automatic maybe_gap();
		if (sender_idle && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// hold the input until every queued point is out, then let the pipeline drain
	task automatic settle_idle();
		in_valid <= 1'b0;
		do @(posedge clk); while (expected_points.size() != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin : result_rx
		point_res_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_points.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result beat: point (%0d,%0d) product=%h",
							point_col, point_row, product);
				end else begin
					want = expected_points.pop_front();
					beats_checked++;
					if (product !== want.product || point_col !== want.col ||
							point_row !== want.row || clipped !== want.clipped ||
							last !== want.last) begin
						fails++;
						if (fails <= 10) begin
							$display("mismatch: want (%0d,%0d) product=%h clipped=%b last=%b",
								want.col, want.row, want.product, want.clipped, want.last);
							$display("           got (%0d,%0d) product=%h clipped=%b last=%b",
								point_col, point_row, product, clipped, last);
						end
					end
				end
			end
			if (stall_left != 0) begin
				out_ready <= 1'b0;
				stall_left--;
			end else if (ready_idle && $urandom_range(0, 11) == 0) begin
				out_ready <= 1'b0;
				stall_left = $urandom_range(0, 9);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	initial begin
		point_res_t        tail;
		logic [SIZE_W-1:0] dim_c, dim_r;
		int unsigned       nc, nr, len;
		int                k;
		logic              cont;

		// reset weights: only the corner term, -1/8
		add_smp(32'h0008_0000, 1'b1);
		add_smp(32'h1234_5678, 1'b0);
		add_smp(32'hFFFF_FFFF, 1'b0);
		add_smp(32'h7FFF_FFFF, 1'b0, 1'b1, 32'hFFFF_0000, 1'b0);
		// corner -1.0: saturation at the top, near-min without clip
		add_cfg(REG_CORNER, 18'h20000);
		add_smp(32'h8000_0000, 1'b1);
		add_smp(32'h0000_0000, 1'b0);
		add_smp(32'h0000_0000, 1'b0);
		add_smp(32'h0000_0000, 1'b0, 1'b1, 32'h7FFF_FFFF, 1'b1);
		add_smp(32'h7FFF_FFFF, 1'b1);
		add_smp(32'h0000_0001, 1'b0);
		add_smp(32'hFFFF_8000, 1'b0);
		add_smp(32'h8000_0000, 1'b0, 1'b1, 32'h8000_0001, 1'b0);
		// corner at max positive
		add_cfg(REG_CORNER, 18'h1FFFF);
		add_smp(32'h8000_0000, 1'b1);
		add_smp(32'hAAAA_5555, 1'b0);
		add_smp(32'h5555_AAAA, 1'b0);
		add_smp(32'h0000_FFFF, 1'b0, 1'b1, 32'h8000_4000, 1'b0);
		// 3x3 grid: interior, edges and corners with every weight in play
		add_cfg(REG_COLS, 18'd3);
		add_cfg(REG_ROWS, 18'd3);
		add_cfg(REG_CORNER, 18'h3C000);
		add_cfg(REG_VERT, 18'h38000);
		add_cfg(REG_HORIZ, 18'h08000);
		add_cfg(REG_VERT_HALF, 18'h1FFFF);
		add_cfg(REG_HORIZ_HALF, 18'h20000);
		add_smp(32'h0001_0000, 1'b1);
		add_smp(32'h7FFF_FFFF, 1'b0);
		add_smp(32'hFFFE_0000, 1'b0);
		add_smp(32'h8000_0000, 1'b0);
		add_smp(32'h0003_8000, 1'b0);
		add_smp(32'h7FFF_FFFF, 1'b0);
		add_smp(32'hFFFF_FFFF, 1'b0);
		add_smp(32'h8000_0000, 1'b0);
		add_smp(32'h0000_0000, 1'b0);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				if (i == 0 || plan[i-1].kind == ROW_SMP) settle_idle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				cfg_we <= 1'b0;
				maybe_gap();
				send_sample(plan[i].smp, plan[i].fs);
				if (plan[i].typed) begin
					tail = expected_points.pop_back();
					tail.product = plan[i].t_prod;
					tail.clipped = plan[i].t_clip;
					expected_points.push_back(tail);
				end
			end
		end

		while (rand_sent < RAND_ITEMS) begin
			settle_idle();
			phases++;
			sender_idle = (rand_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			ready_idle = (rand_sent < QUIET_FROM) && ($urandom_range(0, 3) != 0);
			dim_c = pick_dim();
			dim_r = pick_dim();
			write_reg(REG_COLS, {7'($urandom), dim_c});
			write_reg(REG_ROWS, {7'($urandom), dim_r});
			write_reg(REG_CORNER, pick_weight());
			write_reg(REG_VERT, pick_weight());
			write_reg(REG_HORIZ, pick_weight());
			write_reg(REG_VERT_HALF, pick_weight());
			write_reg(REG_HORIZ_HALF, pick_weight());
			cfg_we <= 1'b0;
			nc = clip_dim(dim_c, MAX_COLS);
			nr = clip_dim(dim_r, MAX_ROWS);
			// continuing phases pick up the old position under the new sizes
			cont = ($urandom_range(0, 3) == 0);
			len = (nc * nr <= 40) ? nc * nr * $urandom_range(1, 3) : $urandom_range(10, 40);
			for (k = 0; k < len && rand_sent < RAND_ITEMS; k++) begin
				if (rand_sent >= QUIET_FROM) begin
					sender_idle = 1'b0;
					ready_idle = 1'b0;
				end
				maybe_gap();
				if (rand_sent == 60) settle_idle();
				send_sample(pick_sample(),
					((k != 0 || !cont) && k % (nc * nr) == 0) || $urandom_range(0, 31) == 0);
				rand_sent++;
			end
		end

		settle_idle();
		$display("run covered %0d samples (%0d random over %0d phases)",
			samples_sent, rand_sent, phases);
		$display("with %0d register writes and %0d points checked", cfg_writes, beats_checked);
		if (fails == 0 && expected_points.size() == 0) begin
			$display("tb_top: PASS");
		end else begin
			$display("%0d bad beats, %0d points never arrived", fails, expected_points.size());
			$display("tb_top: FAIL");
		end
		$finish;
	end

endmodule
